// File: hdl/vbdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vbdm_pkg;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_COUNT = 3'd0,
		REG_VIB_MIN_COUNT = 3'd1,
		REG_DRIFT_MIN_COUNT = 3'd2,
		REG_VIB_RMS_FLOOR = 3'd3,
		REG_GROWTH_RATIO = 3'd4,
		REG_GRAVITY_REF = 3'd5,
		REG_DRIFT_LIMIT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] start_count;
		logic [7:0] vib_min_count;
		logic [7:0] drift_min_count;
		logic [18:0] vib_rms_floor;
		logic [11:0] growth_ratio;
		logic signed [19:0] gravity_ref;
		logic [18:0] drift_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic accum;
		logic eval_go;
		logic div_go;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_idle;
		logic eval_done;
		logic div_last;
	} dp_sts_t;
endpackage
`default_nettype wire

// File: hdl/vibration_and_bias_drift_monitor.sv
// Vibration buildup and accelerometer bias drift monitor.
// Input channel: in_valid/in_ready carry one beat of stamp, vib_value and
// accel_value (signed Q7.12). Output channel: out_valid/out_ready carry one
// beat of event_stamp, vib_buildup and bias_drift for every input beat.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while idle.
// Each item scans the held window once through the sample memories, one
// entry per cycle, waits for the read pipeline to empty, then a bit-serial
// divider forms the window mean of accel_value less gravity_ref.
// out_valid rises once the controller has passed through its scan, flush,
// eval, divide and done states; the next beat is taken only after the
// result is taken, so a new input is not accepted while one is in work.
// Reset clears fill count, pointer, bias state and registers to defaults;
// sample memory contents are undefined until written.
// If the receiver stalls, the result holds and no new input is accepted.
`timescale 1ns / 1ps
`default_nettype none
module vibration_and_bias_drift_monitor
	import vbdm_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] stamp,
	input wire logic signed [19:0] vib_value,
	input wire logic signed [19:0] accel_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] event_stamp,
	output logic vib_buildup,
	output logic bias_drift
);
	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_count <= 8'd10;
			cfg_q.vib_min_count <= 8'd50;
			cfg_q.drift_min_count <= 8'd30;
			cfg_q.vib_rms_floor <= 19'd410;
			cfg_q.growth_ratio <= 12'd384;
			cfg_q.gravity_ref <= 20'sd40182;
			cfg_q.drift_limit <= 19'd205;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_START_COUNT: cfg_q.start_count <= cfg_data[7:0];
				REG_VIB_MIN_COUNT: cfg_q.vib_min_count <= cfg_data[7:0];
				REG_DRIFT_MIN_COUNT: cfg_q.drift_min_count <= cfg_data[7:0];
				REG_VIB_RMS_FLOOR: cfg_q.vib_rms_floor <= cfg_data[18:0];
				REG_GROWTH_RATIO: cfg_q.growth_ratio <= cfg_data[11:0];
				REG_GRAVITY_REF: cfg_q.gravity_ref <= $signed(cfg_data);
				REG_DRIFT_LIMIT: cfg_q.drift_limit <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	vbdm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	vbdm_datapath #(.DEPTH(WINDOW_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .sts(sts),
		.stamp(stamp), .vib_value(vib_value), .accel_value(accel_value),
		.event_stamp(event_stamp), .vib_buildup(vib_buildup), .bias_drift(bias_drift)
	);
endmodule
`default_nettype wire

// File: hdl/vbdm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module vbdm_datapath
	import vbdm_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire dp_cmd_t cmd,
	output dp_sts_t sts,
	input wire logic [31:0] stamp,
	input wire logic signed [19:0] vib_value,
	input wire logic signed [19:0] accel_value,
	output logic [31:0] event_stamp,
	output logic vib_buildup,
	output logic bias_drift
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KW = (CW > 8) ? CW : 8;
	localparam int unsigned EW = 40 + CW;
	localparam int unsigned TW = 20 + CW;
	localparam int unsigned NW = TW + 2;
	localparam int unsigned DW = NW + 1;

	logic signed [19:0] vib_mem [DEPTH];
	logic signed [19:0] acc_mem [DEPTH];
	logic [AW-1:0] wp_q, rd_q;
	logic [CW-1:0] fill_q, idx_q;
	logic [CW-1:0] n_q, mid_q;
	logic signed [19:0] vrd_s1, ard_s1;
	logic rdv_s1, rdold_s1;
	logic signed [39:0] sq_s2;
	logic signed [19:0] a_s2;
	logic v_s2, old_s2;
	logic [EW-1:0] older_q, newer_q;
	logic signed [TW-1:0] total_q;
	logic [31:0] stamp_q;
	logic signed [NW-1:0] num_q;
	logic [NW-1:0] rem_q, quo_q;
	logic neg_q;
	logic [$clog2(NW+1)-1:0] dcnt_q;
	logic signed [21:0] bias_stored_q;
	logic first_q;
	logic [2:0] eph_q;
	logic [EW+CW-1:0] m_a_q;
	logic [EW+CW+24-1:0] m_b_q;
	logic [37+CW:0] m_f_q;
	logic vib_q, drift_q;

	logic [AW-1:0] wp_next;
	logic [CW:0] oldest_sum;
	logic [AW-1:0] oldest;
	logic [NW-1:0] rem_sh;
	logic signed [NW-1:0] bias_full;
	logic signed [22:0] diff;
	logic run_start, run_vib, run_drift;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vib_mem[wp_q] <= vib_value;
			acc_mem[wp_q] <= accel_value;
		end
		vrd_s1 <= vib_mem[rd_q];
		ard_s1 <= acc_mem[rd_q];
	end

	assign wp_next = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign oldest_sum = (CW+1)'(wp_q) + (CW+1)'(DEPTH) - (CW+1)'(fill_q);
	assign oldest = (fill_q == CW'(DEPTH)) ? wp_next :
		(oldest_sum >= (CW+1)'(DEPTH)) ? AW'(oldest_sum - (CW+1)'(DEPTH)) : AW'(oldest_sum);

	assign run_start = KW'(n_q) >= KW'(cfg.start_count);
	assign run_vib = KW'(n_q) >= KW'(cfg.vib_min_count);
	assign run_drift = KW'(n_q) >= KW'(cfg.drift_min_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			first_q <= 1'b1;
			bias_stored_q <= '0;
			rdv_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.accum;
			v_s2 <= rdv_s1;
			if (cmd.load) begin
				wp_q <= wp_next;
				if (fill_q != CW'(DEPTH)) fill_q <= fill_q + 1'b1;
			end
			if (cmd.finish && run_start && run_drift) begin
				if (first_q) begin
					bias_stored_q <= 22'(bias_full);
					first_q <= 1'b0;
				end else if ((diff < 0 ? -diff : diff) > 23'(cfg.drift_limit)) begin
					bias_stored_q <= 22'(bias_full);
				end
			end
		end
	end

	assign bias_full = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign diff = 23'(bias_full) - 23'(bias_stored_q);
	assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};

	always_ff @(posedge clk) begin
		rdold_s1 <= idx_q < mid_q;
		sq_s2 <= vrd_s1 * vrd_s1;
		a_s2 <= ard_s1;
		old_s2 <= rdold_s1;
		if (cmd.clear) begin
			n_q <= (fill_q == CW'(DEPTH)) ? fill_q : fill_q + 1'b1;
			mid_q <= ((fill_q == CW'(DEPTH)) ? fill_q : fill_q + 1'b1) >> 1;
			idx_q <= '0;
			stamp_q <= stamp;
			older_q <= '0;
			newer_q <= '0;
			total_q <= '0;
		end
		if (cmd.load)
			rd_q <= oldest;
		else if (cmd.accum) begin
			rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			idx_q <= idx_q + 1'b1;
		end
		if (v_s2) begin
			if (old_s2) older_q <= older_q + EW'($unsigned(sq_s2));
			else newer_q <= newer_q + EW'($unsigned(sq_s2));
			total_q <= total_q + TW'(a_s2);
		end
		if (cmd.eval_go) eph_q <= 3'd0;
		else if (eph_q != 3'd4) eph_q <= eph_q + 1'b1;
		case (eph_q)
			3'd0: begin
				m_a_q <= (EW+CW)'(newer_q * mid_q);
				m_b_q <= (EW+CW+24)'(older_q * (n_q - mid_q));
				m_f_q <= (38+CW)'(cfg.vib_rms_floor * cfg.vib_rms_floor);
			end
			3'd1: begin
				m_b_q <= (EW+CW+24)'(m_b_q * cfg.growth_ratio);
				m_f_q <= (38+CW)'(m_f_q * mid_q);
			end
			3'd2: m_b_q <= (EW+CW+24)'(m_b_q * cfg.growth_ratio);
			default: ;
		endcase
		if (eph_q == 3'd3)
			vib_q <= (older_q > EW'(m_f_q)) && ({8'd0, m_a_q, 16'd0} > m_b_q)
				&& run_start && run_vib;
		if (cmd.div_go) begin
			num_q <= $signed(NW'(total_q)) - $signed(NW'(n_q)) * NW'(cfg.gravity_ref);
			rem_q <= '0;
			quo_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (dcnt_q == '0) begin
				neg_q <= num_q < 0;
				num_q <= num_q < 0 ? -num_q : num_q;
				dcnt_q <= dcnt_q + 1'b1;
			end else begin
				num_q <= num_q <<< 1;
				if (rem_sh >= NW'(n_q)) begin
					rem_q <= rem_sh - NW'(n_q);
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
		if (cmd.finish) begin
			event_stamp <= stamp_q;
			vib_buildup <= vib_q;
			bias_drift <= !first_q && run_start && run_drift
				&& ((diff < 0 ? -diff : diff) > 23'(cfg.drift_limit));
		end
	end

	assign sts.scan_last = cmd.accum && (idx_q + 1'b1 == n_q);
	assign sts.pipe_idle = !rdv_s1 && !v_s2;
	assign sts.eval_done = (eph_q == 3'd4) && !v_s2 && !rdv_s1;
	assign sts.div_last = cmd.div_step && (dcnt_q == ($clog2(NW+1))'(NW));
endmodule
`default_nettype wire

// File: hdl/vbdm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module vbdm_ctrl
	import vbdm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output dp_cmd_t cmd,
	input wire dp_sts_t sts
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FLUSH, S_EVAL, S_DIV, S_DONE, S_OUT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_ready && in_valid;
		cmd.clear = cmd.load;
		cmd.accum = (state_q == S_SCAN);
		cmd.eval_go = (state_q == S_FLUSH) && sts.pipe_idle;
		cmd.div_go = cmd.eval_go;
		cmd.div_step = (state_q == S_EVAL) || (state_q == S_DIV);
		cmd.finish = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_FLUSH;
				S_FLUSH: if (sts.pipe_idle) state_q <= S_EVAL;
				S_EVAL: state_q <= S_DIV;
				S_DIV: if (sts.div_last && sts.eval_done) state_q <= S_DONE;
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("missing result");
`endif
endmodule
`default_nettype wire
